// File: src/md5p_pkg.sv
`default_nettype none

package md5p_pkg;

    localparam int unsigned COUNT_W = 61;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned PART_W  = 24;
    localparam int unsigned WCNT_W  = 4;

    // Index of the last padding word ahead of the two length words in a 16-word block.
    localparam logic [WCNT_W-1:0] PAD_LAST_CNT = 4'd13;
    localparam logic [7:0]        MARK_BYTE    = 8'h80;

    typedef enum logic [2:0] {
        ST_DATA,
        ST_MARK,
        ST_ZERO,
        ST_LEN_LO,
        ST_LEN_HI
    } state_t;

    typedef enum logic [2:0] {
        OUT_DATA,
        OUT_MARK,
        OUT_ZERO,
        OUT_LEN_LO,
        OUT_LEN_HI
    } out_sel_t;

    typedef struct packed {
        logic     take_byte;
        logic     out_load;
        out_sel_t out_sel;
        logic     word_init;
        logic     word_inc;
        logic     clear_msg;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic pos_is_three;
        logic mark_ends_pad;
        logic zero_ends_pad;
    } status_t;

endpackage

`default_nettype wire

// File: src/md5p_ctrl.sv
`default_nettype none

module md5p_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             byte_present,
    input  wire logic             end_of_message,
    input  wire md5p_pkg::status_t sts,
    output md5p_pkg::cmd_t        cmd,
    output logic                  in_ready
);

    md5p_pkg::state_t state_reg;
    md5p_pkg::state_t state_next;
    logic             fire;

    assign fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= md5p_pkg::ST_DATA;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            md5p_pkg::ST_DATA:
            begin
                if (fire && end_of_message)
                begin
                    state_next = md5p_pkg::ST_MARK;
                end
            end
            md5p_pkg::ST_MARK:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.mark_ends_pad ? md5p_pkg::ST_LEN_LO : md5p_pkg::ST_ZERO;
                end
            end
            md5p_pkg::ST_ZERO:
            begin
                if (sts.out_free && sts.zero_ends_pad)
                begin
                    state_next = md5p_pkg::ST_LEN_LO;
                end
            end
            md5p_pkg::ST_LEN_LO:
            begin
                if (sts.out_free)
                begin
                    state_next = md5p_pkg::ST_LEN_HI;
                end
            end
            md5p_pkg::ST_LEN_HI:
            begin
                if (sts.out_free)
                begin
                    state_next = md5p_pkg::ST_DATA;
                end
            end
            default:
            begin
                state_next = md5p_pkg::ST_DATA;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.take_byte = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.out_sel   = md5p_pkg::OUT_DATA;
        cmd.word_init = 1'b0;
        cmd.word_inc  = 1'b0;
        cmd.clear_msg = 1'b0;
        unique case (state_reg)
            md5p_pkg::ST_DATA:
            begin
                in_ready      = sts.out_free;
                cmd.take_byte = fire && byte_present;
                cmd.out_load  = fire && byte_present && sts.pos_is_three;
                cmd.out_sel   = md5p_pkg::OUT_DATA;
            end
            md5p_pkg::ST_MARK:
            begin
                cmd.out_load  = sts.out_free;
                cmd.out_sel   = md5p_pkg::OUT_MARK;
                cmd.word_init = sts.out_free;
            end
            md5p_pkg::ST_ZERO:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = md5p_pkg::OUT_ZERO;
                cmd.word_inc = sts.out_free;
            end
            md5p_pkg::ST_LEN_LO:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = md5p_pkg::OUT_LEN_LO;
            end
            md5p_pkg::ST_LEN_HI:
            begin
                cmd.out_load  = sts.out_free;
                cmd.out_sel   = md5p_pkg::OUT_LEN_HI;
                cmd.clear_msg = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/md5p_datapath.sv
`default_nettype none

module md5p_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [7:0]                     data_byte,
    input  wire md5p_pkg::cmd_t                 cmd,
    input  wire logic                           out_ready,
    output md5p_pkg::status_t                   sts,
    output logic                                out_valid,
    output logic [md5p_pkg::WORD_W-1:0]         block_word,
    output logic                                final_word
);

    logic [md5p_pkg::COUNT_W-1:0] count_reg;
    logic [md5p_pkg::COUNT_W-1:0] count_next;
    logic [md5p_pkg::PART_W-1:0]  partial_reg;
    logic [md5p_pkg::PART_W-1:0]  partial_next;
    logic [md5p_pkg::WCNT_W-1:0]  wcnt_reg;
    logic [md5p_pkg::WCNT_W-1:0]  wcnt_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [md5p_pkg::WORD_W-1:0]  out_word_reg;
    logic [md5p_pkg::WORD_W-1:0]  out_word_next;
    logic                         out_final_reg;
    logic                         out_final_next;
    logic [1:0]                   pos;
    logic [4:0]                   shift;

    assign pos   = count_reg[1:0];
    assign shift = {pos, 3'b000};

    assign sts.out_free      = !out_valid_reg || out_ready;
    assign sts.pos_is_three  = (pos == 2'd3);
    assign sts.mark_ends_pad = (count_reg[5:2] == md5p_pkg::PAD_LAST_CNT);
    assign sts.zero_ends_pad = (wcnt_reg == md5p_pkg::PAD_LAST_CNT);

    always_comb
    begin
        count_next   = count_reg;
        partial_next = partial_reg;
        if (cmd.clear_msg)
        begin
            count_next   = '0;
            partial_next = '0;
        end
        else if (cmd.take_byte)
        begin
            count_next = count_reg + md5p_pkg::COUNT_W'(1);
            if (pos == 2'd3)
            begin
                partial_next = '0;
            end
            else
            begin
                partial_next = partial_reg | (md5p_pkg::PART_W'(data_byte) << shift);
            end
        end
    end

    always_comb
    begin
        wcnt_next = wcnt_reg;
        if (cmd.word_init)
        begin
            wcnt_next = count_reg[5:2] + md5p_pkg::WCNT_W'(1);
        end
        else if (cmd.word_inc)
        begin
            wcnt_next = wcnt_reg + md5p_pkg::WCNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        out_final_next = out_final_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_final_next = 1'b0;
            unique case (cmd.out_sel)
                md5p_pkg::OUT_DATA:
                begin
                    out_word_next = {data_byte, partial_reg};
                end
                md5p_pkg::OUT_MARK:
                begin
                    out_word_next = {8'h00, partial_reg}
                                  | (md5p_pkg::WORD_W'(md5p_pkg::MARK_BYTE) << shift);
                end
                md5p_pkg::OUT_ZERO:
                begin
                    out_word_next = '0;
                end
                md5p_pkg::OUT_LEN_LO:
                begin
                    out_word_next = {count_reg[28:0], 3'b000};
                end
                md5p_pkg::OUT_LEN_HI:
                begin
                    out_word_next  = count_reg[60:29];
                    out_final_next = 1'b1;
                end
                default:
                begin
                    out_word_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            partial_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            partial_reg   <= partial_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wcnt_reg      <= wcnt_next;
        out_word_reg  <= out_word_next;
        out_final_reg <= out_final_next;
    end

    assign out_valid  = out_valid_reg;
    assign block_word = out_word_reg;
    assign final_word = out_final_reg;

endmodule

`default_nettype wire

// File: src/md5_message_padder_core.sv
// MD5 message padder. Message bytes arrive one per beat and are packed four to a
// little-endian 32-bit word, first byte least significant. A beat with
// end_of_message set closes the message: the block emits the 0x80 marker word, zero
// words up to 448 mod 512 bits, then the 64-bit bit length as two words, low word
// first, with final_word set on the last one. A beat with byte_present clear and
// end_of_message set pads the bytes taken so far (an empty message if none). Data
// beats are taken one per cycle as long as the output register drains. The closing
// beat is followed by 3 to 18 padding words, one per cycle while the output register
// drains, during which no input is taken; that count is set by the padding sequencer,
// which emits the words through the single output register. The byte count wraps modulo 2^61.
`default_nettype none

module md5_message_padder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      block_word,
    output logic             final_word
);

    md5p_pkg::cmd_t    cmd;
    md5p_pkg::status_t sts;

    md5p_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .sts            (sts),
        .cmd            (cmd),
        .in_ready       (in_ready)
    );

    md5p_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .cmd        (cmd),
        .out_ready  (out_ready),
        .sts        (sts),
        .out_valid  (out_valid),
        .block_word (block_word),
        .final_word (final_word)
    );

`ifndef SYNTHESIS
    // A pending result is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output register loaded while a result was pending");

    // Padding words are never produced while input is being taken.
    a_pad_excludes_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_sel != md5p_pkg::OUT_DATA) |-> !in_ready)
        else $error("padding word emitted while input is open");

    // Once the last length word is taken, the next message may start at once,
    // unless a closing beat was taken on that same edge.
    a_ready_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && final_word
            && !(in_valid && in_ready && end_of_message)) |=> in_ready)
        else $error("input not reopened after the final word");
`endif

endmodule

`default_nettype wire

// File: sim/md5_message_padder_core_tb.sv
`timescale 1ns / 100ps

module md5_message_padder_core_tb;

    localparam int         ITEM_TARGET    = 450;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         REPORT_LIMIT   = 10;
    localparam logic [7:0] PAD_MARK       = 8'h80;
    localparam logic [3:0] LENGTH_SLOT    = 4'd14;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } padded_word_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_SPARSE,
        RX_COIN,
        RX_MASK
    } rx_mode_e;

    class pad_scoreboard;
        logic [60:0]  msg_bytes;
        logic [23:0]  partial;
        padded_word_t pending[$];
        int           mismatches;

        function new();
            msg_bytes  = '0;
            partial    = '0;
            mismatches = 0;
        endfunction

        function void queue_word(logic [31:0] word, logic last);
            padded_word_t w;
            w.word = word;
            w.last = last;
            pending.push_back(w);
        endfunction

        // Computes every padded word that one accepted input beat releases.
        function void take_beat(logic [7:0] data, logic present, logic eom);
            logic [1:0]  pos;
            logic [3:0]  slot;
            logic [63:0] bits;
            if (present)
            begin
                pos = msg_bytes[1:0];
                if (pos == 2'd3)
                begin
                    queue_word({data, partial}, 1'b0);
                    partial = '0;
                end
                else
                    partial = partial | (24'(data) << (8 * pos));
                msg_bytes = msg_bytes + 61'd1;
            end
            if (eom)
            begin
                pos = msg_bytes[1:0];
                queue_word({8'h00, partial} | (32'(PAD_MARK) << (8 * pos)), 1'b0);
                // Slot of the next word within its 16-word block.
                slot = msg_bytes[5:2] + 4'd1;
                while (slot != LENGTH_SLOT)
                begin
                    queue_word(32'h0, 1'b0);
                    slot = slot + 4'd1;
                end
                bits = {msg_bytes, 3'b000};
                queue_word(bits[31:0], 1'b0);
                queue_word(bits[63:32], 1'b1);
                msg_bytes = '0;
                partial   = '0;
            end
        endfunction

        function void check_word(logic [31:0] word, logic last);
            padded_word_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: word %h final %b arrived with nothing pending",
                             $realtime, word, last);
            end
            else
            begin
                want = pending.pop_front();
                if (want.word !== word || want.last !== last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: word exp %h got %h, final exp %b got %b",
                                 $realtime, want.word, word, want.last, last);
                end
            end
        endfunction
    endclass

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic [7:0]  data_byte      = 8'h00;
    logic        byte_present   = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_ready      = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [31:0] block_word;
    logic        final_word;

    pad_scoreboard sb;
    int            burst_left    = 0;
    int            payload_items = 0;
    int            quiet_cycles  = 0;
    rx_mode_e      rx_mode       = RX_OPEN;
    int            rx_left       = 0;
    logic [7:0]    rx_mask       = 8'hFF;
    logic [2:0]    rx_phase      = 3'd0;

    md5_message_padder_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .block_word     (block_word),
        .final_word     (final_word)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.take_beat(data_byte, byte_present, end_of_message);
        if (rst_n && out_valid && out_ready)
            sb.check_word(block_word, final_word);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("[md5_message_padder_core] ERROR");
            $finish;
        end
    end

    // The receiver switches at random between four stall styles.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_left = $urandom_range(32, 200);
            rx_mask = 8'($urandom_range(1, 255));
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            default:   out_ready <= rx_mask[rx_phase];
        endcase
    end

    task automatic send_beat(input logic [7:0] d, input logic p, input logic e);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid       <= 1'b1;
        data_byte      <= d;
        byte_present   <= p;
        end_of_message <= e;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (p || e)
            payload_items++;
    endtask

    // A message either closes on its last byte or with a separate empty beat.
    task automatic send_message(input int len, input logic close_on_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
        end
        if (!close_on_byte || len == 0)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        int len;
        sb = new();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Empty message, then an idle beat that must produce nothing.
        send_beat(8'h5A, 1'b0, 1'b1);
        send_beat(8'hA5, 1'b0, 1'b0);
        // One-byte message closed on the byte itself.
        send_beat(8'hFF, 1'b1, 1'b1);
        // Four bytes with an idle beat inside, closed by an empty beat.
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h33, 1'b0, 1'b0);
        send_beat(8'h80, 1'b1, 1'b0);
        send_beat(8'h7F, 1'b1, 1'b0);
        send_beat(8'hC3, 1'b0, 1'b1);
        // Two bytes then an empty close, marker lands in the third byte.
        send_beat(8'h55, 1'b1, 1'b0);
        send_beat(8'hAA, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        // Three bytes closed on the third, marker in the top byte.
        send_beat(8'h01, 1'b1, 1'b0);
        send_beat(8'hFE, 1'b1, 1'b0);
        send_beat(8'h10, 1'b1, 1'b1);
        // Back-to-back empty messages after padding.
        send_beat(8'hFF, 1'b0, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);

        // Lengths near 56 bytes decide whether padding spills into a second block.
        while (payload_items < ITEM_TARGET)
        begin
            case ($urandom_range(0, 5))
                0, 1:    len = $urandom_range(52, 68);
                2:       len = $urandom_range(0, 4);
                5:       len = $urandom_range(69, 140);
                default: len = $urandom_range(5, 51);
            endcase
            // The last message is cut short so the run stays near its item budget.
            if (len > ITEM_TARGET - payload_items)
                len = ITEM_TARGET - payload_items;
            send_message(len, 1'($urandom_range(0, 1)));
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[md5_message_padder_core] OK");
        else
            $display("[md5_message_padder_core] ERROR");
        $finish;
    end

endmodule

// File: files.f
src/md5p_pkg.sv
src/md5p_ctrl.sv
src/md5p_datapath.sv
src/md5_message_padder_core.sv
sim/md5_message_padder_core_tb.sv
